/* sv/gapf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapf_pkg
// Shared widths, register indexes, status codes, axis code decode and the
// axis routing type of the grid permute and flip address generator.
// ----------------------------------------------------------------------------
package gapf_pkg;

    localparam int IDX_W     = 30;
    localparam int DATA_W    = 64;
    localparam int SIZE_W    = 11;
    localparam int ORDER_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // depth of the result queue, also the credit limit of the back part
    localparam int OUT_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_THIRD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_THIRD  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;

    // signed axis codes, two's complement in three bits
    localparam logic [ORDER_W-1:0] ORDER_POS1 = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_POS2 = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_POS3 = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_NEG3 = 3'd5;
    localparam logic [ORDER_W-1:0] ORDER_NEG2 = 3'd6;
    localparam logic [ORDER_W-1:0] ORDER_NEG1 = 3'd7;

    typedef struct packed {
        logic            bad;   // invalid or repeated axis code
        logic [2:0]      rev;   // per source axis: reversed
        logic [2:0][1:0] sel;   // per target axis: which source axis lands there
    } gapf_axes_t;

    // returns {valid, target axis}
    function automatic logic [2:0] decode_order(input logic [ORDER_W-1:0] code);
        logic [2:0] res;
        unique case (code)
            ORDER_POS1, ORDER_NEG1: res = 3'b100;
            ORDER_POS2, ORDER_NEG2: res = 3'b101;
            ORDER_POS3, ORDER_NEG3: res = 3'b110;
            default:                res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

/* sv/grid_axis_permute_flip_address.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_axis_permute_flip_address
// Reorders a structured 3D grid: source linear index to destination index
// after per-axis reversal and axis permutation, data word passed through.
// ----------------------------------------------------------------------------
// route from accept to result: input register, the two bit-per-stage dividers, front
//   output register, middle queue, the back stages and the result queue
// throughput: one item per cycle while full is low, both dividers fully pipelined
// reset: sizes 1, axis codes 1 2 3, all queues empty; no clearing pass
// ----------------------------------------------------------------------------
module grid_axis_permute_flip_address #(
    parameter int MAX_AXIS_SIZE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [gapf_pkg::IDX_W-1:0]        source_index,
    input  logic [gapf_pkg::DATA_W-1:0]       data_word,
    output logic                              empty,
    input  logic                              pop,
    output logic [gapf_pkg::STATUS_W-1:0]     status,
    output logic [gapf_pkg::IDX_W-1:0]        dest_index,
    output logic [gapf_pkg::DATA_W-1:0]       data_out,
    output logic [gapf_pkg::SIZE_W-1:0]       new_size_first,
    output logic [gapf_pkg::SIZE_W-1:0]       new_size_second,
    output logic [gapf_pkg::SIZE_W-1:0]       new_size_third,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gapf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gapf_pkg::SIZE_W-1:0]       cfg_data
);

    import gapf_pkg::*;

    localparam int EFF_MAX   = (MAX_AXIS_SIZE < 2047) ? MAX_AXIS_SIZE : 2047;
    localparam int SW        = $clog2(EFF_MAX + 1);
    localparam int CW        = (EFF_MAX > 2) ? $clog2(EFF_MAX) : 1;
    localparam int PW        = 2 * SW;
    localparam int TW        = 3 * SW;
    localparam int MID_DEPTH = 2 * CW + 4;
    localparam int MID_W     = STATUS_W + 3 * CW + DATA_W;
    localparam int RES_W     = STATUS_W + IDX_W + DATA_W;

    logic                    accept;
    logic [2:0][SW-1:0]      eff;
    logic [PW-1:0]           plane;
    logic [TW-1:0]           total;
    logic [SW-1:0]           dim0;
    logic [PW-1:0]           dim01;
    logic [2:0][SIZE_W-1:0]  new_size;
    gapf_axes_t              axes;

    logic                    mid_push;
    logic                    mid_pop;
    logic                    mid_empty;
    logic                    mid_full;
    logic [STATUS_W-1:0]     f_status;
    logic [2:0][CW-1:0]      f_coord;
    logic [DATA_W-1:0]       f_data;
    logic [MID_W-1:0]        mid_rdata;
    logic [2:0][CW-1:0]      b_coord;

    logic                    res_push;
    logic                    res_pop;
    logic                    res_full;
    logic [STATUS_W-1:0]     b_status;
    logic [IDX_W-1:0]        b_dest;
    logic [DATA_W-1:0]       b_data;
    logic [RES_W-1:0]        res_rdata;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign res_pop   = pop && !empty;

    gapf_cfg #(
        .MAX_AXIS_SIZE (MAX_AXIS_SIZE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff),
        .plane     (plane),
        .total     (total),
        .dim0      (dim0),
        .dim01     (dim01),
        .new_size  (new_size),
        .axes      (axes)
    );

    gapf_front #(
        .MAX_AXIS_SIZE (MAX_AXIS_SIZE),
        .QUEUE_DEPTH   (MID_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_push    (accept),
        .in_index   (source_index),
        .in_data    (data_word),
        .plane      (plane),
        .total      (total),
        .eff        (eff),
        .axes       (axes),
        .queue_pop  (mid_pop),
        .full       (full),
        .out_valid  (mid_push),
        .out_status (f_status),
        .out_coord  (f_coord),
        .out_data   (f_data)
    );

    gapf_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata ({f_status, f_coord, f_data}),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .full  (mid_full)
    );

    assign b_coord = mid_rdata[DATA_W +: 3 * CW];

    gapf_back #(
        .MAX_AXIS_SIZE (MAX_AXIS_SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (mid_empty),
        .in_status   (mid_rdata[MID_W-1 -: STATUS_W]),
        .in_coord    (b_coord),
        .in_data     (mid_rdata[DATA_W-1:0]),
        .axes        (axes),
        .dim0        (dim0),
        .dim01       (dim01),
        .res_pop     (res_pop),
        .queue_pop   (mid_pop),
        .out_push    (res_push),
        .out_status  (b_status),
        .out_dest    (b_dest),
        .out_data    (b_data)
    );

    gapf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({b_status, b_dest, b_data}),
        .pop   (res_pop),
        .rdata (res_rdata),
        .empty (empty),
        .full  (res_full)
    );

    assign status          = res_rdata[RES_W-1 -: STATUS_W];
    assign dest_index      = res_rdata[DATA_W +: IDX_W];
    assign data_out        = res_rdata[DATA_W-1:0];
    // the user must change sizes only while no item is in flight; the block does not enforce it
    assign new_size_first  = new_size[0];
    assign new_size_second = new_size[1];
    assign new_size_third  = new_size[2];

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("middle queue written while full");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result queue written while full");

    a_bad_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == STATUS_BAD_ORDER)) |-> (dest_index == '0))
        else $error("bad axis codes with nonzero destination");

    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == STATUS_OK || status == STATUS_BAD_ORDER ||
                    status == STATUS_RANGE))
        else $error("undefined status code on result");

endmodule

/* sv/gapf_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapf_fifo
// Small flop based first-in first-out queue with count, used between the
// front and back parts and on the result side.
// ----------------------------------------------------------------------------
module gapf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PTW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg;
    logic [PTW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [PTW-1:0]   wr_ptr_next;
    logic [PTW-1:0]   rd_ptr_next;
    logic [CNTW-1:0]  cnt_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNTW'(do_push) - CNTW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/gapf_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapf_cfg
// Configuration registers and the values derived from them: clamped sizes,
// plane and grid products, axis routing and the reordered sizes.
// ----------------------------------------------------------------------------
module gapf_cfg #(
    parameter  int MAX_AXIS_SIZE = 1024,
    localparam int EFF_MAX = (MAX_AXIS_SIZE < 2047) ? MAX_AXIS_SIZE : 2047,
    localparam int SW = $clog2(EFF_MAX + 1),
    localparam int PW = 2 * SW,
    localparam int TW = 3 * SW
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [gapf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gapf_pkg::SIZE_W-1:0]        cfg_data,
    output logic [2:0][SW-1:0]                 eff,
    output logic [PW-1:0]                      plane,
    output logic [TW-1:0]                      total,
    output logic [SW-1:0]                      dim0,
    output logic [PW-1:0]                      dim01,
    output logic [2:0][gapf_pkg::SIZE_W-1:0]   new_size,
    output gapf_pkg::gapf_axes_t               axes
);

    import gapf_pkg::*;

    logic [2:0][SIZE_W-1:0]  size_reg;
    logic [2:0][ORDER_W-1:0] order_reg;

    logic [2:0][2:0]         dec;
    logic [2:0]              ok;
    logic [2:0][1:0]         ax;
    logic [2:0][SW-1:0]      dims;
    gapf_axes_t              axes_next;
    logic [2:0][SIZE_W-1:0]  new_size_next;

    logic [PW-1:0]           plane_reg;
    logic [TW-1:0]           total_reg;
    logic [SW-1:0]           dim0_reg;
    logic [PW-1:0]           dim01_reg;
    logic [2:0][SIZE_W-1:0]  new_size_reg;
    gapf_axes_t              axes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0]  <= SIZE_RESET;
            size_reg[1]  <= SIZE_RESET;
            size_reg[2]  <= SIZE_RESET;
            order_reg[0] <= ORDER_POS1;
            order_reg[1] <= ORDER_POS2;
            order_reg[2] <= ORDER_POS3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIZE_FIRST:   size_reg[0]  <= cfg_data;
                REG_SIZE_SECOND:  size_reg[1]  <= cfg_data;
                REG_SIZE_THIRD:   size_reg[2]  <= cfg_data;
                REG_ORDER_FIRST:  order_reg[0] <= cfg_data[ORDER_W-1:0];
                REG_ORDER_SECOND: order_reg[1] <= cfg_data[ORDER_W-1:0];
                REG_ORDER_THIRD:  order_reg[2] <= cfg_data[ORDER_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            // sizes above the supported maximum saturate
            eff[a] = (32'(size_reg[a]) > EFF_MAX) ? SW'(EFF_MAX) : SW'(size_reg[a]);
            dec[a] = decode_order(order_reg[a]);
            ok[a]  = dec[a][2];
            ax[a]  = dec[a][1:0];
        end
        axes_next.bad = !(&ok) || (ax[0] == ax[1]) || (ax[1] == ax[2]) || (ax[0] == ax[2]);
        axes_next.rev = {order_reg[2][ORDER_W-1], order_reg[1][ORDER_W-1],
                         order_reg[0][ORDER_W-1]};
        axes_next.sel = '0;
        for (int a = 0; a < 3; a++)
        begin
            axes_next.sel[ax[a]] = 2'(a);
        end
        for (int t = 0; t < 3; t++)
        begin
            dims[t]          = eff[axes_next.sel[t]];
            // with bad codes the clamped source sizes are reported in source order
            new_size_next[t] = SIZE_W'(axes_next.bad ? eff[t] : dims[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg    <= PW'(eff[0]) * PW'(eff[1]);
        total_reg    <= TW'(plane_reg) * TW'(eff[2]);
        dim0_reg     <= dims[0];
        dim01_reg    <= PW'(dims[0]) * PW'(dims[1]);
        new_size_reg <= new_size_next;
        axes_reg     <= axes_next;
    end

    assign plane    = plane_reg;
    assign total    = total_reg;
    assign dim0     = dim0_reg;
    assign dim01    = dim01_reg;
    assign new_size = new_size_reg;
    assign axes     = axes_reg;

endmodule

/* sv/gapf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapf_front
// Accepts items, splits the linear index into three coordinates with two
// pipelined restoring dividers, classifies the item and applies reversal.
// ----------------------------------------------------------------------------
module gapf_front #(
    parameter  int MAX_AXIS_SIZE = 1024,
    parameter  int QUEUE_DEPTH = 24,
    localparam int EFF_MAX = (MAX_AXIS_SIZE < 2047) ? MAX_AXIS_SIZE : 2047,
    localparam int SW = $clog2(EFF_MAX + 1),
    localparam int CW = (EFF_MAX > 2) ? $clog2(EFF_MAX) : 1,
    localparam int PW = 2 * SW,
    localparam int TW = 3 * SW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_push,
    input  logic [gapf_pkg::IDX_W-1:0]        in_index,
    input  logic [gapf_pkg::DATA_W-1:0]       in_data,
    input  logic [PW-1:0]                     plane,
    input  logic [TW-1:0]                     total,
    input  logic [2:0][SW-1:0]                eff,
    input  gapf_pkg::gapf_axes_t              axes,
    input  logic                              queue_pop,
    output logic                              full,
    output logic                              out_valid,
    output logic [gapf_pkg::STATUS_W-1:0]     out_status,
    output logic [2:0][CW-1:0]                out_coord,
    output logic [gapf_pkg::DATA_W-1:0]       out_data
);

    import gapf_pkg::*;

    localparam int NS   = 2 * CW;
    localparam int CMPW = (IDX_W > PW + CW) ? IDX_W : PW + CW;
    localparam int XW   = (TW > IDX_W) ? TW : IDX_W;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [NS:0]       vld_reg;
    logic [IDX_W-1:0]  idx_reg  [NS+1];
    logic [IDX_W-1:0]  rem_reg  [NS+1];
    logic [CW-1:0]     qa_reg   [NS+1];
    logic [CW-1:0]     qb_reg   [NS+1];
    logic [DATA_W-1:0] data_reg [NS+1];

    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   cnt_next;

    logic [2:0][CW-1:0] pos;
    logic [2:0][CW-1:0] coord_next;
    logic [STATUS_W-1:0] status_next;
    logic [SW-1:0]      flip [3];
    logic               oor;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [2:0][CW-1:0]  out_coord_reg;
    logic [DATA_W-1:0]   out_data_reg;

    // credits cover the pipeline plus the queue behind it
    assign full     = (cnt_reg >= CNTW'(QUEUE_DEPTH));
    assign cnt_next = cnt_reg + CNTW'(in_push) - CNTW'(queue_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            vld_reg[0] <= in_push;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0]  <= in_index;
        rem_reg[0]  <= in_index;
        qa_reg[0]   <= '0;
        qb_reg[0]   <= '0;
        data_reg[0] <= in_data;
    end

    // first CW stages divide by the plane size, the next CW by the first size
    for (genvar s = 1; s <= NS; s++)
    begin : g_div
        localparam int B = (s <= CW) ? CW - s : NS - s;

        logic [CMPW-1:0] dvs;
        logic [CMPW-1:0] num;
        logic            ge;

        always_comb
        begin
            dvs = ((s <= CW) ? CMPW'(plane) : CMPW'(eff[0])) << B;
            num = CMPW'(rem_reg[s-1]);
            ge  = (num >= dvs);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            idx_reg[s]  <= idx_reg[s-1];
            data_reg[s] <= data_reg[s-1];
            rem_reg[s]  <= ge ? IDX_W'(num - dvs) : rem_reg[s-1];
            if (s <= CW)
            begin
                qa_reg[s] <= (qa_reg[s-1] << 1) | CW'(ge);
                qb_reg[s] <= qb_reg[s-1];
            end
            else
            begin
                qa_reg[s] <= qa_reg[s-1];
                qb_reg[s] <= (qb_reg[s-1] << 1) | CW'(ge);
            end
        end
    end

    always_comb
    begin
        pos[0] = rem_reg[NS][CW-1:0];
        pos[1] = qb_reg[NS];
        pos[2] = qa_reg[NS];
        oor    = (XW'(idx_reg[NS]) >= XW'(total));
        for (int a = 0; a < 3; a++)
        begin
            flip[a]       = eff[a] - SW'(1) - SW'(pos[a]);
            coord_next[a] = axes.rev[a] ? flip[a][CW-1:0] : pos[a];
        end
        // bad codes win over the range check
        priority if (axes.bad)
        begin
            status_next = STATUS_BAD_ORDER;
        end
        else if (oor)
        begin
            status_next = STATUS_RANGE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= status_next;
        out_coord_reg  <= coord_next;
        out_data_reg   <= data_reg[NS];
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_coord  = out_coord_reg;
    assign out_data   = out_data_reg;

endmodule

/* sv/gapf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapf_back
// Takes classified items from the middle queue, routes the coordinates to
// their target axes and forms the destination index in two stages.
// ----------------------------------------------------------------------------
module gapf_back #(
    parameter  int MAX_AXIS_SIZE = 1024,
    localparam int EFF_MAX = (MAX_AXIS_SIZE < 2047) ? MAX_AXIS_SIZE : 2047,
    localparam int SW = $clog2(EFF_MAX + 1),
    localparam int CW = (EFF_MAX > 2) ? $clog2(EFF_MAX) : 1,
    localparam int PW = 2 * SW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              queue_empty,
    input  logic [gapf_pkg::STATUS_W-1:0]     in_status,
    input  logic [2:0][CW-1:0]                in_coord,
    input  logic [gapf_pkg::DATA_W-1:0]       in_data,
    input  gapf_pkg::gapf_axes_t              axes,
    input  logic [SW-1:0]                     dim0,
    input  logic [PW-1:0]                     dim01,
    input  logic                              res_pop,
    output logic                              queue_pop,
    output logic                              out_push,
    output logic [gapf_pkg::STATUS_W-1:0]     out_status,
    output logic [gapf_pkg::IDX_W-1:0]        out_dest,
    output logic [gapf_pkg::DATA_W-1:0]       out_data
);

    import gapf_pkg::*;

    localparam int CNTW = $clog2(OUT_DEPTH + 1);

    logic [CNTW-1:0]     cnt_reg;
    logic                launch;

    logic [2:0][CW-1:0]  c;
    logic [CW+SW-1:0]    prod1;
    logic [IDX_W-1:0]    t1_next;

    logic                v1_reg;
    logic [STATUS_W-1:0] st1_reg;
    logic [IDX_W-1:0]    t1_reg;
    logic [CW-1:0]       c2_reg;
    logic [DATA_W-1:0]   data1_reg;

    logic [CW+PW-1:0]    prod2;
    logic [IDX_W-1:0]    dest_next;

    logic                v2_reg;
    logic [STATUS_W-1:0] st2_reg;
    logic [IDX_W-1:0]    dest_reg;
    logic [DATA_W-1:0]   data2_reg;

    // credits cover both stages plus the result queue
    assign launch    = !queue_empty && (cnt_reg < CNTW'(OUT_DEPTH));
    assign queue_pop = launch;

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            c[t] = in_coord[axes.sel[t]];
        end
        prod1   = (CW+SW)'(c[1]) * (CW+SW)'(dim0);
        t1_next = IDX_W'(c[0]) + IDX_W'(prod1);
        prod2   = (CW+PW)'(c2_reg) * (CW+PW)'(dim01);
        dest_next = (st1_reg == STATUS_OK) ? t1_reg + IDX_W'(prod2) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + CNTW'(launch) - CNTW'(res_pop);
            v1_reg  <= launch;
            v2_reg  <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg   <= in_status;
        t1_reg    <= t1_next;
        c2_reg    <= c[2];
        data1_reg <= in_data;
        st2_reg   <= st1_reg;
        dest_reg  <= dest_next;
        data2_reg <= data1_reg;
    end

    assign out_push   = v2_reg;
    assign out_status = st2_reg;
    assign out_dest   = dest_reg;
    assign out_data   = data2_reg;

endmodule
